// File: hdl/ccmr_pkg.sv
// ----------------------------------------------------------------------------
// ccmr_pkg
// Shared types and constants of the calendar clock minute rollover unit.
// ----------------------------------------------------------------------------
package ccmr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam int unsigned IN_REC_W   = 47;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_REC_W  = 51;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [6:0]  SEC_PER_MIN     = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR    = 7'd60;
  localparam logic [6:0]  MIN_HALF_HOUR   = 7'd30;
  localparam logic [5:0]  MIN_TWENTY      = 6'd20;
  localparam logic [5:0]  MIN_FIFTY       = 6'd50;
  localparam logic [4:0]  HOURS_HALF_DAY  = 5'd12;
  localparam logic [3:0]  HOUR_FIRST      = 4'd1;
  localparam logic [2:0]  WEEKDAY_LIMIT   = 3'd7;
  localparam logic [9:0]  DOY_LIMIT       = 10'h16E;
  localparam logic [9:0]  DOY_LIMIT_LEAP  = 10'h16F;
  localparam logic [8:0]  DOY_FIRST       = 9'd1;
  localparam logic [1:0]  LEAP_YEAR_MASK  = 2'd3;

  localparam logic [5:0]  RST_TRIGGER_BASE            = 6'd0;
  localparam logic [5:0]  RST_TRIGGER_BASE_PLUS_HALF  = 6'd30;
  localparam logic [5:0]  RST_TRIGGER_HALF_MINUS_BASE = 6'd30;
  localparam logic [5:0]  RST_TRIGGER_HOUR_MINUS_BASE = 6'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_BASE            = 2'd0,
    CFG_TRIGGER_BASE_PLUS_HALF  = 2'd1,
    CFG_TRIGGER_HALF_MINUS_BASE = 2'd2,
    CFG_TRIGGER_HOUR_MINUS_BASE = 2'd3
  } ccmr_cfg_idx_e;

  typedef enum logic [2:0] {
    EVT_NONE       = 3'd0,
    EVT_MINUTE     = 3'd1,
    EVT_HALF_HOUR  = 3'd2,
    EVT_TRIGGER_B  = 3'd3,
    EVT_MINUTE_20  = 3'd4,
    EVT_TRIGGER_A  = 3'd5
  } ccmr_event_e;

  typedef struct packed {
    logic [5:0] trigger_base;
    logic [5:0] trigger_base_plus_half;
    logic [5:0] trigger_half_minus_base;
    logic [5:0] trigger_hour_minus_base;
  } ccmr_cfg_t;

  typedef struct packed {
    logic        in_leap;
    logic [15:0] in_year;
    logic [8:0]  in_day_of_year;
    logic [2:0]  in_weekday;
    logic        in_pm;
    logic [3:0]  in_hour;
    logic [5:0]  in_minute;
    logic [6:0]  in_second;
  } ccmr_in_rec_t;

  typedef struct packed {
    ccmr_event_e event_code;
    logic        new_day;
    logic        new_leap;
    logic [15:0] new_year;
    logic [8:0]  new_day_of_year;
    logic [2:0]  new_weekday;
    logic        new_pm;
    logic [3:0]  new_hour;
    logic [5:0]  new_minute;
    logic [6:0]  new_second;
  } ccmr_out_rec_t;

endpackage

// File: hdl/ccmr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccmr_cfg_regs
// Holds the four minute trigger registers written through the write port.
// ----------------------------------------------------------------------------
module ccmr_cfg_regs import ccmr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output ccmr_cfg_t             cfg_o
);

  ccmr_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ccmr_cfg_idx_e'(cfg_index_i))
        CFG_TRIGGER_BASE:            cfg_d.trigger_base            = cfg_wdata_i;
        CFG_TRIGGER_BASE_PLUS_HALF:  cfg_d.trigger_base_plus_half  = cfg_wdata_i;
        CFG_TRIGGER_HALF_MINUS_BASE: cfg_d.trigger_half_minus_base = cfg_wdata_i;
        CFG_TRIGGER_HOUR_MINUS_BASE: cfg_d.trigger_hour_minus_base = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_base            <= RST_TRIGGER_BASE;
      cfg_q.trigger_base_plus_half  <= RST_TRIGGER_BASE_PLUS_HALF;
      cfg_q.trigger_half_minus_base <= RST_TRIGGER_HALF_MINUS_BASE;
      cfg_q.trigger_hour_minus_base <= RST_TRIGGER_HOUR_MINUS_BASE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/ccmr_tick_logic.sv
// ----------------------------------------------------------------------------
// ccmr_tick_logic
// Combinational minute rollover: carries seconds into minute, hour, day and
// year, and classifies the new minute into an event code.
// ----------------------------------------------------------------------------
module ccmr_tick_logic import ccmr_pkg::*; (
  input  ccmr_in_rec_t  rec_i,
  input  ccmr_cfg_t     cfg_i,
  output ccmr_out_rec_t rec_o
);

  logic        sec_tick;
  logic [6:0]  min_inc;
  logic [4:0]  hour_inc;
  logic [2:0]  wday_inc;
  logic [2:0]  wday_next;
  logic [9:0]  doy_inc;
  logic [9:0]  doy_limit;
  logic [15:0] year_inc;

  assign sec_tick  = rec_i.in_second >= SEC_PER_MIN;
  assign min_inc   = {1'b0, rec_i.in_minute} + 7'd1;
  assign hour_inc  = {1'b0, rec_i.in_hour} + 5'd1;
  assign wday_inc  = rec_i.in_weekday + 3'd1;
  assign wday_next = (wday_inc == WEEKDAY_LIMIT) ? 3'd0 : wday_inc;
  assign doy_inc   = {1'b0, rec_i.in_day_of_year} + 10'd1;
  assign doy_limit = rec_i.in_leap ? DOY_LIMIT_LEAP : DOY_LIMIT;
  assign year_inc  = rec_i.in_year + 16'd1;

  always_comb begin
    rec_o.new_second      = rec_i.in_second;
    rec_o.new_minute      = rec_i.in_minute;
    rec_o.new_hour        = rec_i.in_hour;
    rec_o.new_pm          = rec_i.in_pm;
    rec_o.new_weekday     = rec_i.in_weekday;
    rec_o.new_day_of_year = rec_i.in_day_of_year;
    rec_o.new_year        = rec_i.in_year;
    rec_o.new_leap        = rec_i.in_leap;
    rec_o.new_day         = 1'b0;
    rec_o.event_code      = EVT_NONE;
    if (sec_tick) begin
      rec_o.new_second = rec_i.in_second - SEC_PER_MIN;
      rec_o.new_minute = min_inc[5:0];
      rec_o.event_code = EVT_MINUTE;
      priority if (min_inc == MIN_HALF_HOUR) begin
        rec_o.event_code = EVT_HALF_HOUR;
      end else if (min_inc >= MIN_PER_HOUR) begin
        rec_o.new_minute = 6'd0;
        rec_o.event_code = EVT_HALF_HOUR;
        if (hour_inc > HOURS_HALF_DAY) begin
          rec_o.new_hour = HOUR_FIRST;
        end else begin
          rec_o.new_hour = hour_inc[3:0];
          if (hour_inc == HOURS_HALF_DAY) begin
            rec_o.new_pm = ~rec_i.in_pm;
            // Midnight is the flip from afternoon to morning.
            if (rec_i.in_pm) begin
              rec_o.new_day     = 1'b1;
              rec_o.new_weekday = wday_next;
              if (doy_inc >= doy_limit) begin
                rec_o.new_year        = year_inc;
                rec_o.new_day_of_year = DOY_FIRST;
                rec_o.new_leap        = (year_inc[1:0] & LEAP_YEAR_MASK) == 2'd0;
              end else begin
                rec_o.new_day_of_year = doy_inc[8:0];
              end
            end
          end
        end
      end else if (min_inc[5:0] == cfg_i.trigger_base ||
                   min_inc[5:0] == cfg_i.trigger_base_plus_half) begin
        rec_o.event_code = EVT_TRIGGER_A;
      end else if (min_inc[5:0] == MIN_TWENTY || min_inc[5:0] == MIN_FIFTY) begin
        rec_o.event_code = EVT_MINUTE_20;
      end else if (min_inc[5:0] == cfg_i.trigger_half_minus_base ||
                   min_inc[5:0] == cfg_i.trigger_hour_minus_base) begin
        rec_o.event_code = EVT_TRIGGER_B;
      end else begin
        rec_o.event_code = EVT_MINUTE;
      end
    end
  end

endmodule

// File: hdl/calendar_clock_minute_rollover_unit.sv
// ----------------------------------------------------------------------------
// calendar_clock_minute_rollover_unit
// Advances a twelve-hour calendar clock record by one minute when its second
// count has reached a full minute, and flags minute events.
// ----------------------------------------------------------------------------
// The unit takes one clock record per cycle while the output side is not
// stalled and returns one updated record for each, in order, through the
// input register and then the result register, with the rollover and event
// logic between them. Both stages hold their contents while the output is
// stalled, so up to two records are in flight. The user must write trigger
// registers through the write port only while no record is in flight; the
// block itself does not enforce this. They reset to 0, 30, 30 and 60.
// ----------------------------------------------------------------------------
module calendar_clock_minute_rollover_unit import ccmr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: in_second, in_minute, in_hour, in_pm, in_weekday,
  // in_day_of_year, in_year, in_leap, zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: new_second, new_minute, new_hour, new_pm, new_weekday,
  // new_day_of_year, new_year, new_leap, new_day, event_code, zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ccmr_cfg_t     cfg;
  ccmr_in_rec_t  in_rec_q;
  ccmr_out_rec_t tick_rec;
  ccmr_out_rec_t out_rec_q;
  logic          in_valid_q;
  logic          out_valid_q;
  logic          out_ready;
  logic          in_ready;

  ccmr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ccmr_tick_logic u_tick_logic (
    .rec_i (in_rec_q),
    .cfg_i (cfg),
    .rec_o (tick_rec)
  );

  assign out_ready = !out_valid_q || m_axis_tready;
  assign in_ready  = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_rec_q <= ccmr_in_rec_t'(s_axis_tdata[IN_REC_W-1:0]);
    end
    if (out_ready && in_valid_q) begin
      out_rec_q <= tick_rec;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_REC_W){1'b0}}, out_rec_q};

endmodule

// File: hdl/ccmr_checker.sv
// ----------------------------------------------------------------------------
// ccmr_checker
// Port-level checks of the calendar clock minute rollover unit.
// ----------------------------------------------------------------------------
module ccmr_checker import ccmr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ccmr_out_rec_t out_rec;

  assign out_rec = ccmr_out_rec_t'(m_axis_tdata[OUT_REC_W-1:0]);

  // A stalled result transfer keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_REC_W] == '0)
    else $error("result fill bits not zero");

  // With no result waiting, the input side always has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output side is empty");

  // A record without a minute tick never advances the day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_rec.event_code == EVT_NONE |-> !out_rec.new_day)
    else $error("day advanced without a minute tick");

  // A day advance happens only at midnight, which also carries the half-hour event code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_rec.new_day |->
      out_rec.new_minute == 6'd0 && out_rec.new_hour == HOURS_HALF_DAY[3:0] &&
      !out_rec.new_pm && out_rec.event_code == EVT_HALF_HOUR)
    else $error("day advanced outside midnight");

endmodule

bind calendar_clock_minute_rollover_unit ccmr_checker u_ccmr_checker (.*);
